@@ rtl/imu_serial_frame_parser_assert.svh @@
// ---------------------------------------------------------------------------
// IMU serial frame parser assertion macros
// Shared concurrent assertion wrappers for the parser modules.
// ---------------------------------------------------------------------------
`ifndef IMU_SERIAL_FRAME_PARSER_ASSERT_SVH
`define IMU_SERIAL_FRAME_PARSER_ASSERT_SVH

// Check an implication on every clock edge outside reset
`define ISFP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds on any clock edge outside reset
`define ISFP_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ rtl/isfp_pkg.sv @@
// ---------------------------------------------------------------------------
// IMU serial frame parser package
// Shared types, register indexes and field constants.
// ---------------------------------------------------------------------------
`default_nettype none

package isfp_pkg;

  localparam int FRAME_LENGTH_DEF = 11;
  localparam int POS_W            = 5;
  localparam int BYTE_W           = 8;
  localparam int AXIS_W           = 16;
  localparam int KIND_W           = 2;
  localparam int PADDR_W          = 4;
  localparam int PDATA_W          = 32;

  // Byte positions of the decoded fields within a frame
  localparam int TYPE_BYTE        = 1;
  localparam int X_LO_BYTE        = 2;
  localparam int Y_LO_BYTE        = 4;
  localparam int Z_LO_BYTE        = 6;
  localparam int T_LO_BYTE        = 8;
  localparam int LAST_FIELD_BYTE  = 9;

  // Register indexes
  localparam logic [1:0] REG_HEADER = 2'd0;
  localparam logic [1:0] REG_ACCEL  = 2'd1;
  localparam logic [1:0] REG_GYRO   = 2'd2;
  localparam logic [1:0] REG_ANGLE  = 2'd3;

  localparam logic [BYTE_W-1:0] HEADER_RST = 8'd85;
  localparam logic [BYTE_W-1:0] ACCEL_RST  = 8'd81;
  localparam logic [BYTE_W-1:0] GYRO_RST   = 8'd82;
  localparam logic [BYTE_W-1:0] ANGLE_RST  = 8'd83;

  // Frame kinds
  localparam logic [KIND_W-1:0] KIND_ACCEL = 2'd0;
  localparam logic [KIND_W-1:0] KIND_GYRO  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ANGLE = 2'd2;

  typedef struct packed {
    logic [BYTE_W-1:0] header_byte;
    logic [BYTE_W-1:0] accel_type_code;
    logic [BYTE_W-1:0] gyro_type_code;
    logic [BYTE_W-1:0] angle_type_code;
  } cfg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic [POS_W-1:0]  pos;
    logic              last;
    logic              sum_ok;
  } queue_entry_t;

endpackage

`default_nettype wire

@@ rtl/isfp_front.sv @@
// ---------------------------------------------------------------------------
// IMU serial frame parser front end
// Hunts for the header, tracks byte position and checksum, queues beats.
// ---------------------------------------------------------------------------
`default_nettype none

module isfp_front #(
  parameter int FRAME_LENGTH = isfp_pkg::FRAME_LENGTH_DEF
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire  [isfp_pkg::BYTE_W-1:0]       header_byte,
  input  wire                               in_valid,
  output logic                              in_ready,
  input  wire  [isfp_pkg::BYTE_W-1:0]       in_rx_byte,
  output logic                              push_valid,
  input  wire                               push_ready,
  output isfp_pkg::queue_entry_t            push_entry
);

  localparam logic [isfp_pkg::POS_W-1:0] LAST_POS = isfp_pkg::POS_W'(FRAME_LENGTH - 1);

  logic [isfp_pkg::POS_W-1:0]  pos_r, pos_nxt;
  logic [isfp_pkg::BYTE_W-1:0] sum_r, sum_nxt;
  logic                        accept;
  logic                        keep;
  logic                        is_last;

  assign in_ready = push_ready;
  assign accept   = in_valid && in_ready;
  assign keep     = (pos_r != '0) || (in_rx_byte == header_byte);
  assign is_last  = (pos_r == LAST_POS);

  always_comb begin
    push_valid        = in_valid && keep;
    push_entry.data   = in_rx_byte;
    push_entry.pos    = pos_r;
    push_entry.last   = is_last;
    push_entry.sum_ok = (sum_r == in_rx_byte);
  end

  always_comb begin
    pos_nxt = pos_r;
    sum_nxt = sum_r;
    if (accept && keep) begin
      if (is_last) begin
        pos_nxt = '0;
        sum_nxt = '0;
      end else begin
        pos_nxt = pos_r + isfp_pkg::POS_W'(1);
        sum_nxt = sum_r + in_rx_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      sum_r <= '0;
    end else begin
      pos_r <= pos_nxt;
      sum_r <= sum_nxt;
    end
  end

`include "imu_serial_frame_parser_assert.svh"

`ISFP_ASSERT_NEVER(a_pos_in_frame, pos_r > LAST_POS, "byte position beyond frame")
`ISFP_ASSERT(a_last_clears, accept && keep && is_last |=> pos_r == '0 && sum_r == '0, "frame end did not clear")

endmodule

`default_nettype wire

@@ rtl/isfp_queue.sv @@
// ---------------------------------------------------------------------------
// IMU serial frame parser queue
// Two-entry queue decoupling the front end from the frame decoder.
// ---------------------------------------------------------------------------
`default_nettype none

module isfp_queue (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     push_valid,
  output logic                    push_ready,
  input  isfp_pkg::queue_entry_t  push_entry,
  output logic                    pop_valid,
  input  wire                     pop_ready,
  output isfp_pkg::queue_entry_t  pop_entry
);

  isfp_pkg::queue_entry_t entry_r [0:1];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  logic       pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_entry  = entry_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

`include "imu_serial_frame_parser_assert.svh"

`ISFP_ASSERT_NEVER(a_cnt_range, cnt_r == 2'd3, "queue count overflow")
`ISFP_ASSERT(a_ptr_match, cnt_r == 2'd0 || cnt_r == 2'd2 |-> wr_ptr_r == rd_ptr_r, "queue pointers out of step")

endmodule

`default_nettype wire

@@ rtl/isfp_back.sv @@
// ---------------------------------------------------------------------------
// IMU serial frame parser back end
// Stores frame bytes, checks sum and type at frame end and registers results.
// ---------------------------------------------------------------------------
`default_nettype none

module isfp_back (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  isfp_pkg::cfg_t                      cfg,
  input  wire                                 pop_valid,
  output logic                                pop_ready,
  input  isfp_pkg::queue_entry_t              pop_entry,
  output logic                                out_valid,
  input  wire                                 out_ready,
  output logic [isfp_pkg::KIND_W-1:0]         out_frame_kind,
  output logic signed [isfp_pkg::AXIS_W-1:0]  out_axis_x,
  output logic signed [isfp_pkg::AXIS_W-1:0]  out_axis_y,
  output logic signed [isfp_pkg::AXIS_W-1:0]  out_axis_z,
  output logic signed [isfp_pkg::AXIS_W-1:0]  out_temperature
);

  localparam int LO = isfp_pkg::TYPE_BYTE;
  localparam int HI = isfp_pkg::LAST_FIELD_BYTE;

  logic [isfp_pkg::BYTE_W-1:0] store_r [LO:HI];
  logic [isfp_pkg::BYTE_W-1:0] view    [LO:HI];

  logic                               pop;
  logic                               type_hit;
  logic [isfp_pkg::KIND_W-1:0]        kind;
  logic                               emit;
  logic                               out_valid_r, out_valid_nxt;
  logic [isfp_pkg::KIND_W-1:0]        kind_r;
  logic [isfp_pkg::AXIS_W-1:0]        x_r, y_r, z_r, t_r;

  assign pop_ready = !out_valid_r || out_ready;
  assign pop       = pop_valid && pop_ready;

  for (genvar i = LO; i <= HI; i++) begin : g_store
    always_ff @(posedge clk) begin
      if (pop && pop_entry.pos == isfp_pkg::POS_W'(i)) begin
        store_r[i] <= pop_entry.data;
      end
    end

    // the checksum byte may itself be a field byte in the shortest frame
    assign view[i] = (pop_entry.last && pop_entry.pos == isfp_pkg::POS_W'(i)) ?
                     pop_entry.data : store_r[i];
  end

  always_comb begin
    type_hit = 1'b1;
    kind     = isfp_pkg::KIND_ACCEL;
    if (view[isfp_pkg::TYPE_BYTE] == cfg.accel_type_code) begin
      kind = isfp_pkg::KIND_ACCEL;
    end else if (view[isfp_pkg::TYPE_BYTE] == cfg.gyro_type_code) begin
      kind = isfp_pkg::KIND_GYRO;
    end else if (view[isfp_pkg::TYPE_BYTE] == cfg.angle_type_code) begin
      kind = isfp_pkg::KIND_ANGLE;
    end else begin
      type_hit = 1'b0;
    end
  end

  assign emit = pop && pop_entry.last && pop_entry.sum_ok && type_hit;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      kind_r <= kind;
      x_r    <= {view[isfp_pkg::X_LO_BYTE + 1], view[isfp_pkg::X_LO_BYTE]};
      y_r    <= {view[isfp_pkg::Y_LO_BYTE + 1], view[isfp_pkg::Y_LO_BYTE]};
      z_r    <= {view[isfp_pkg::Z_LO_BYTE + 1], view[isfp_pkg::Z_LO_BYTE]};
      t_r    <= (kind == isfp_pkg::KIND_ACCEL) ?
                {view[isfp_pkg::T_LO_BYTE + 1], view[isfp_pkg::T_LO_BYTE]} : '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_frame_kind  = kind_r;
  assign out_axis_x      = x_r;
  assign out_axis_y      = y_r;
  assign out_axis_z      = z_r;
  assign out_temperature = t_r;

`include "imu_serial_frame_parser_assert.svh"

`ISFP_ASSERT(a_emit_shows, emit |=> out_valid_r, "accepted frame not presented")
`ISFP_ASSERT(a_no_idle_stall, pop_valid && !out_valid_r |-> pop, "decoder stalled with free output")

endmodule

`default_nettype wire

@@ rtl/imu_serial_frame_parser.sv @@
// ---------------------------------------------------------------------------
// IMU serial frame parser
// Parses checksummed IMU serial frames into raw axis counts.
//
// Input channel in_*: one received serial byte per beat. Bytes are dropped
// until the header byte arrives; a frame of FRAME_LENGTH bytes is then
// collected, the last being the 8-bit sum of all others.
// Result channel out_*: one beat per good frame of known type, carrying the
// kind, three signed axis counts and temperature (zero unless acceleration).
// Throughput: one byte per cycle while the queue has room, set by the running
// sum and position counter in the front end; a two-entry queue feeds the
// decoder. Path: the last byte's beat passes through the queue registers,
// then through the output register that drives out_valid.
// Receiver stall: the output register holds, the queue fills, then in_ready
// falls until the result is taken.
// Reset: control registers take their defaults; parser resumes header hunt.
// Configuration: APB registers at 0x0 header, 0x4 accel, 0x8 gyro, 0xC angle.
// ---------------------------------------------------------------------------
`default_nettype none

module imu_serial_frame_parser #(
  parameter int FRAME_LENGTH = isfp_pkg::FRAME_LENGTH_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 psel,
  input  wire                                 penable,
  input  wire                                 pwrite,
  input  wire  [isfp_pkg::PADDR_W-1:0]        paddr,
  input  wire  [isfp_pkg::PDATA_W-1:0]        pwdata,
  output logic [isfp_pkg::PDATA_W-1:0]        prdata,
  output logic                                pready,
  input  wire                                 in_valid,
  output logic                                in_ready,
  input  wire  [isfp_pkg::BYTE_W-1:0]         in_rx_byte,
  output logic                                out_valid,
  input  wire                                 out_ready,
  output logic [isfp_pkg::KIND_W-1:0]         out_frame_kind,
  output logic signed [isfp_pkg::AXIS_W-1:0]  out_axis_x,
  output logic signed [isfp_pkg::AXIS_W-1:0]  out_axis_y,
  output logic signed [isfp_pkg::AXIS_W-1:0]  out_axis_z,
  output logic signed [isfp_pkg::AXIS_W-1:0]  out_temperature
);

  isfp_pkg::cfg_t         cfg_r, cfg_nxt;
  logic                   cfg_wr;
  logic [1:0]             cfg_idx;
  logic                   push_valid;
  logic                   push_ready;
  isfp_pkg::queue_entry_t push_entry;
  logic                   pop_valid;
  logic                   pop_ready;
  isfp_pkg::queue_entry_t pop_entry;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[3:2];

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      unique case (cfg_idx)
        isfp_pkg::REG_HEADER: cfg_nxt.header_byte     = pwdata[isfp_pkg::BYTE_W-1:0];
        isfp_pkg::REG_ACCEL:  cfg_nxt.accel_type_code = pwdata[isfp_pkg::BYTE_W-1:0];
        isfp_pkg::REG_GYRO:   cfg_nxt.gyro_type_code  = pwdata[isfp_pkg::BYTE_W-1:0];
        isfp_pkg::REG_ANGLE:  cfg_nxt.angle_type_code = pwdata[isfp_pkg::BYTE_W-1:0];
        default:              cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      isfp_pkg::REG_HEADER: prdata[isfp_pkg::BYTE_W-1:0] = cfg_r.header_byte;
      isfp_pkg::REG_ACCEL:  prdata[isfp_pkg::BYTE_W-1:0] = cfg_r.accel_type_code;
      isfp_pkg::REG_GYRO:   prdata[isfp_pkg::BYTE_W-1:0] = cfg_r.gyro_type_code;
      isfp_pkg::REG_ANGLE:  prdata[isfp_pkg::BYTE_W-1:0] = cfg_r.angle_type_code;
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.header_byte     <= isfp_pkg::HEADER_RST;
      cfg_r.accel_type_code <= isfp_pkg::ACCEL_RST;
      cfg_r.gyro_type_code  <= isfp_pkg::GYRO_RST;
      cfg_r.angle_type_code <= isfp_pkg::ANGLE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  isfp_front #(
    .FRAME_LENGTH (FRAME_LENGTH)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .header_byte (cfg_r.header_byte),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_rx_byte  (in_rx_byte),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_entry  (push_entry)
  );

  isfp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry)
  );

  isfp_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .pop_valid       (pop_valid),
    .pop_ready       (pop_ready),
    .pop_entry       (pop_entry),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_frame_kind  (out_frame_kind),
    .out_axis_x      (out_axis_x),
    .out_axis_y      (out_axis_y),
    .out_axis_z      (out_axis_z),
    .out_temperature (out_temperature)
  );

endmodule

`default_nettype wire
